### design/courtesy_lamp_timeout_fader_core_defines.svh
// Assertion macros shared by the courtesy lamp fader RTL.
// Depends on nothing; files that assert include it by name.
`ifndef COURTESY_LAMP_TIMEOUT_FADER_CORE_DEFINES_SVH
`define COURTESY_LAMP_TIMEOUT_FADER_CORE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CLF_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define CLF_ASSERT(label, prop, msg) \
  `CLF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### design/clf_pkg.sv
// Types and constants of the courtesy lamp timeout fader.
// No dependencies; used by the interfaces, the step logic and the top level.
`default_nettype none

package clf_pkg;

  localparam int unsigned HOLD_W   = 17;
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned DUTY_W   = 13;
  localparam int unsigned DOOR_W   = 8;
  localparam int unsigned REMOTE_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = HOLD_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_HOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [HOLD_W-1:0] RST_SHORT_HOLD  = 17'd3125;
  localparam logic [HOLD_W-1:0] RST_LONG_HOLD   = 17'd75000;
  localparam logic [HOLD_W-1:0] RST_UNLOCK_HOLD = 17'd7500;
  localparam logic [STEP_W-1:0] RST_RAMP_STEP   = 10'd57;
  localparam logic [DUTY_W-1:0] RST_START_DUTY  = 13'd41;
  localparam logic [DUTY_W-1:0] RST_FULL_DUTY   = 13'd5000;

  typedef enum logic [REMOTE_W-1:0] {
    REM_NONE   = 2'd0,
    REM_UNLOCK = 2'd1,
    REM_LOCK   = 2'd2
  } remote_e;

  typedef struct packed {
    logic [HOLD_W-1:0] short_hold_ticks;
    logic [HOLD_W-1:0] long_hold_ticks;
    logic [HOLD_W-1:0] unlock_open_hold_ticks;
    logic [STEP_W-1:0] ramp_step;
    logic [DUTY_W-1:0] ramp_start_duty;
    logic [DUTY_W-1:0] full_duty;
  } cfg_t;

  typedef struct packed {
    logic              ignition_on;
    logic [DOOR_W-1:0] door_open_mask;
    logic [REMOTE_W-1:0] remote_event;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              duty_update;
    logic              lamp_cut;
    logic              lamp_request;
  } result_t;

  // Lamp state other than the remembered door mask.
  typedef struct packed {
    logic [HOLD_W-1:0] hold_count;
    logic              previous_request;
    logic              previous_ignition;
    logic              fading_in;
    logic              fading_out;
    logic [DUTY_W-1:0] duty_level;
  } state_t;

endpackage

`default_nettype wire

### design/clf_if.sv
// Request channels of the courtesy lamp fader: tick input and result output.
// Depends on clf_pkg for the field widths.
`default_nettype none

interface clf_in_if
  import clf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                ignition_on;
  logic [DOOR_W-1:0]   door_open_mask;
  logic [REMOTE_W-1:0] remote_event;

  modport source (output valid, ignition_on, door_open_mask, remote_event, input ready);
  modport sink   (input valid, ignition_on, door_open_mask, remote_event, output ready);
endinterface

interface clf_out_if
  import clf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;
  logic              duty_update;
  logic              lamp_cut;
  logic              lamp_request;

  modport source (output valid, pwm_duty, duty_update, lamp_cut, lamp_request, input ready);
  modport sink   (input valid, pwm_duty, duty_update, lamp_cut, lamp_request, output ready);
endinterface

`default_nettype wire

### design/clf_step.sv
// Next-state and result logic for one lamp tick: hold timer and fade engine.
// Depends on clf_pkg; instantiated by the top level.
`default_nettype none

module clf_step
  import clf_pkg::*;
#(
  parameter int unsigned DOOR_BITS = 8
) (
  input  cfg_t   cfg_i,
  input  state_t state_i,
  input  logic [((DOOR_BITS < DOOR_W) ? DOOR_BITS : DOOR_W)-1:0] doors_prev_i,
  input  item_t  item_i,
  output state_t state_o,
  output logic [((DOOR_BITS < DOOR_W) ? DOOR_BITS : DOOR_W)-1:0] doors_prev_o,
  output result_t result_o
);

  localparam int unsigned DoorW = (DOOR_BITS < DOOR_W) ? DOOR_BITS : DOOR_W;

  logic [DoorW-1:0]  doors;
  logic              doors_zero;
  logic              ign;
  logic              req;
  logic [HOLD_W-1:0] hold;
  logic [DUTY_W-1:0] duty;
  logic [DUTY_W:0]   sum_up;
  logic [DUTY_W:0]   full_plus2;
  logic              fade_in;
  logic              fade_out;
  logic              written;
  logic              cut;

  always_comb begin
    doors        = item_i.door_open_mask[DoorW-1:0];
    doors_zero   = (doors == '0);
    ign          = item_i.ignition_on;
    state_o      = state_i;
    doors_prev_o = doors_prev_i;
    written      = 1'b0;
    cut          = 1'b0;

    // Countdown: the request reflects the count at the start of the tick.
    req  = (state_i.hold_count != '0);
    hold = req ? state_i.hold_count - HOLD_W'(1) : '0;

    // Ignition edge.
    if (state_i.previous_ignition != ign) begin
      state_o.previous_ignition = ign;
      if (!ign) begin
        hold = doors_zero ? cfg_i.short_hold_ticks : cfg_i.long_hold_ticks;
      end else begin
        hold = '0;
      end
    end
    if (ign && doors_zero) begin
      hold = '0;
    end

    // Door change.
    if (doors_prev_i != doors) begin
      doors_prev_o = doors;
      if (!doors_zero) begin
        hold = cfg_i.long_hold_ticks;
      end else if (hold != '0) begin
        hold = cfg_i.short_hold_ticks;
      end
    end

    // Remote key event; the unused code is ignored.
    case (remote_e'(item_i.remote_event))
      REM_UNLOCK: begin
        if (!ign) begin
          hold = doors_zero ? cfg_i.short_hold_ticks : cfg_i.unlock_open_hold_ticks;
        end
      end
      REM_LOCK: begin
        if (doors_zero) begin
          hold = '0;
        end
      end
      default: begin
      end
    endcase
    state_o.hold_count = hold;

    // Fade engine.
    duty       = state_i.duty_level;
    fade_in    = state_i.fading_in;
    fade_out   = state_i.fading_out;
    sum_up     = {1'b0, duty} + {{(DUTY_W + 1 - STEP_W){1'b0}}, cfg_i.ramp_step};
    full_plus2 = {1'b0, cfg_i.full_duty} + {{DUTY_W{1'b0}}, 1'b1} + {{DUTY_W{1'b0}}, 1'b1};
    if (fade_in) begin
      if (duty > cfg_i.full_duty) begin
        fade_in = 1'b0;
        duty    = full_plus2[DUTY_W] ? DUTY_MAX : full_plus2[DUTY_W-1:0];
      end else begin
        duty    = sum_up[DUTY_W] ? DUTY_MAX : sum_up[DUTY_W-1:0];
      end
      written = 1'b1;
    end
    if (fade_out) begin
      if ({{(DUTY_W - STEP_W){1'b0}}, cfg_i.ramp_step} > duty) begin
        fade_out = 1'b0;
        duty     = '0;
        cut      = 1'b1;
      end else begin
        duty = duty - {{(DUTY_W - STEP_W){1'b0}}, cfg_i.ramp_step};
      end
      written = 1'b1;
    end

    // A change of request starts a new ramp, except in the tick a fade out ends.
    if (!cut && (req != state_i.previous_request)) begin
      state_o.previous_request = req;
      if (req) begin
        fade_in  = 1'b1;
        fade_out = 1'b0;
        duty     = cfg_i.ramp_start_duty;
      end else begin
        fade_in  = 1'b0;
        fade_out = 1'b1;
        duty     = cfg_i.full_duty;
      end
    end
    state_o.fading_in  = fade_in;
    state_o.fading_out = fade_out;
    state_o.duty_level = duty;

    result_o.pwm_duty     = duty;
    result_o.duty_update  = written;
    result_o.lamp_cut     = cut;
    result_o.lamp_request = req;
  end

endmodule

`default_nettype wire

### design/courtesy_lamp_timeout_fader_core.sv
// Courtesy lamp timeout fader: a request passes the input register, then the result
// register, before its result is valid. Throughput one tick per cycle while the output
// is ready; the input side stalls only when both registers are full and it is not ready.
// Reset (asynchronous, active low) clears the hold timer and the fade state and loads
// the configuration registers with their default values.
`default_nettype none
`include "courtesy_lamp_timeout_fader_core_defines.svh"

module courtesy_lamp_timeout_fader_core
  import clf_pkg::*;
#(
  parameter int unsigned DOOR_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clf_in_if.sink                in_i,
  clf_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DoorW = (DOOR_BITS < DOOR_W) ? DOOR_BITS : DOOR_W;

  cfg_t             cfg_q;
  state_t           state_q;
  state_t           state_d;
  logic [DoorW-1:0] doors_q;
  logic [DoorW-1:0] doors_d;
  logic             in_valid_q;
  item_t            item_q;
  logic             out_valid_q;
  result_t          result_q;
  result_t          result_d;
  logic             advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_hold_ticks       <= RST_SHORT_HOLD;
      cfg_q.long_hold_ticks        <= RST_LONG_HOLD;
      cfg_q.unlock_open_hold_ticks <= RST_UNLOCK_HOLD;
      cfg_q.ramp_step              <= RST_RAMP_STEP;
      cfg_q.ramp_start_duty        <= RST_START_DUTY;
      cfg_q.full_duty              <= RST_FULL_DUTY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHORT_HOLD:  cfg_q.short_hold_ticks       <= cfg_data_i;
        CFG_LONG_HOLD:   cfg_q.long_hold_ticks        <= cfg_data_i;
        CFG_UNLOCK_HOLD: cfg_q.unlock_open_hold_ticks <= cfg_data_i;
        CFG_RAMP_STEP:   cfg_q.ramp_step              <= cfg_data_i[STEP_W-1:0];
        CFG_START_DUTY:  cfg_q.ramp_start_duty        <= cfg_data_i[DUTY_W-1:0];
        CFG_FULL_DUTY:   cfg_q.full_duty              <= cfg_data_i[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held tick moves on when the result register is free or being emptied.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.ignition_on    <= in_i.ignition_on;
      item_q.door_open_mask <= in_i.door_open_mask;
      item_q.remote_event   <= in_i.remote_event;
    end
  end

  clf_step #(
    .DOOR_BITS (DOOR_BITS)
  ) u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .doors_prev_i (doors_q),
    .item_i       (item_q),
    .state_o      (state_d),
    .doors_prev_o (doors_d),
    .result_o     (result_d)
  );

  // Lamp state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      doors_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        doors_q     <= doors_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pwm_duty     = result_q.pwm_duty;
  assign out_o.duty_update  = result_q.duty_update;
  assign out_o.lamp_cut     = result_q.lamp_cut;
  assign out_o.lamp_request = result_q.lamp_request;

  // Checks on the fade engine and the pipeline.
  `CLF_ASSERT(a_fade_exclusive, !(state_q.fading_in && state_q.fading_out), "fade in and out both active")
  `CLF_ASSERT(a_cut_zero_duty, out_valid_q && result_q.lamp_cut |-> (result_q.pwm_duty == '0) && result_q.duty_update, "lamp cut without zero duty write")
  `CLF_ASSERT(a_cut_ends_fade, advance && result_d.lamp_cut |=> !state_q.fading_out, "fade out still running after lamp cut")
  `CLF_ASSERT(a_held_tick_kept, in_valid_q && !advance |=> in_valid_q && $stable(item_q), "held tick lost or changed while stalled")

endmodule

`default_nettype wire
